@@ src/srt_pkg.sv @@
// ----------------------------------------------------------------------------
// srt_pkg: slice request tracker shared definitions
// Widths, codes, controller types and the slice length helper.
// ----------------------------------------------------------------------------
package srt_pkg;

   localparam int SLICE_SHIFT = 14;
   localparam int SLICE_BYTES = 1 << SLICE_SHIFT;
   localparam int MAX_SLICES  = 64;
   localparam int IDX_W       = $clog2(MAX_SLICES);
   localparam int CNT_W       = $clog2(MAX_SLICES + 1);
   localparam int GRP_SIZE    = 8;
   localparam int SUB_W       = $clog2(GRP_SIZE);
   localparam int GRP_CNT     = MAX_SLICES / GRP_SIZE;
   localparam int GRP_W       = IDX_W - SUB_W;

   localparam int PLEN_W = 21;
   localparam int PNUM_W = 32;
   localparam int OFF_W  = 20;
   localparam int LEN_W  = 15;
   localparam int CSR_W  = 32;

   localparam logic [PLEN_W-1:0] PLEN_RESET = PLEN_W'(16384);

   typedef enum logic [1:0] {
      KIND_RESTART  = 2'd0,
      KIND_REQUEST  = 2'd1,
      KIND_ABORT    = 2'd2,
      KIND_COMPLETE = 2'd3
   } kind_type;

   typedef enum logic {
      CSR_PIECE_LENGTH = 1'b0,
      CSR_PIECE_NUMBER = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FIND,
      ST_UPDATE,
      ST_SUM,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic load;
      logic find;
      logic update;
      logic sum;
      logic respond;
   } cmd_type;

   // byte length of slice idx; caller guarantees the slice exists
   function automatic logic [LEN_W-1:0] slice_size(input logic [IDX_W-1:0] idx,
                                                   input logic [PLEN_W-1:0] plen);
      logic [PLEN_W-1:0] start_b;
      logic [PLEN_W-1:0] rest;
      start_b = PLEN_W'({idx, {SLICE_SHIFT{1'b0}}});
      rest    = plen - start_b;
      if (rest > PLEN_W'(SLICE_BYTES))
         return LEN_W'(SLICE_BYTES);
      else
         return rest[LEN_W-1:0];
   endfunction

endpackage

@@ src/srt_ctrl.sv @@
// ----------------------------------------------------------------------------
// srt_ctrl: slice request tracker sequencer
// Walks each accepted item through find, update, sum and response cycles.
// ----------------------------------------------------------------------------
module srt_ctrl
   import srt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   output cmd_type cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_FIND;
         end
         ST_FIND:   state_in = ST_UPDATE;
         ST_UPDATE: state_in = ST_SUM;
         ST_SUM:    state_in = ST_RESP;
         ST_RESP:   state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            busy     = reset;
            cmd.load = start & ~reset;
         end
         ST_FIND:   cmd.find    = 1'b1;
         ST_UPDATE: cmd.update  = 1'b1;
         ST_SUM:    cmd.sum     = 1'b1;
         ST_RESP:   cmd.respond = 1'b1;
         default:   busy        = 1'b1;
      endcase
   end

endmodule

@@ src/srt_dpath.sv @@
// ----------------------------------------------------------------------------
// srt_dpath: slice request tracker datapath
// Slice state vectors, grouped first-fit search, exact-match update and
// grouped status reduction.
// ----------------------------------------------------------------------------
module srt_dpath
   import srt_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   input  logic              csr_write,
   input  csr_index_type     csr_index,
   input  logic [CSR_W-1:0]  csr_wdata,
   input  logic [1:0]        req_kind,
   input  logic [OFF_W-1:0]  req_start_offset,
   input  logic [LEN_W-1:0]  req_length_given,
   input  logic              req_endgame,
   output logic              rsp_ok,
   output logic [PNUM_W-1:0] rsp_granted_piece,
   output logic [OFF_W-1:0]  rsp_granted_offset,
   output logic [LEN_W-1:0]  rsp_granted_length,
   output logic              rsp_all_completed,
   output logic              rsp_none_requested,
   output logic              rsp_has_free_slice
);

   logic [PLEN_W-1:0]     piece_length_ff;
   logic [PNUM_W-1:0]     piece_number_ff;
   logic [MAX_SLICES-1:0] req_vec_ff, req_vec_in;
   logic [MAX_SLICES-1:0] done_vec_ff, done_vec_in;

   kind_type              kind_ff;
   logic [OFF_W-1:0]      off_ff;
   logic [LEN_W-1:0]      len_ff;
   logic                  endgame_ff;

   logic [GRP_CNT-1:0]    grp_any_ff, grp_any_in;
   logic [SUB_W-1:0]      grp_first_ff [GRP_CNT];
   logic [SUB_W-1:0]      grp_first_in [GRP_CNT];
   logic                  match_ff, match_in;

   logic                  ok_ff, ok_in;
   logic [PNUM_W-1:0]     gp_ff, gp_in;
   logic [OFF_W-1:0]      go_ff, go_in;
   logic [LEN_W-1:0]      gl_ff, gl_in;

   logic [GRP_CNT-1:0]    grp_done_ff, grp_done_in;
   logic [GRP_CNT-1:0]    grp_none_ff, grp_none_in;
   logic [GRP_CNT-1:0]    grp_free_ff, grp_free_in;

   logic [CNT_W:0]        raw_count;
   logic [CNT_W-1:0]      slice_count;
   logic [MAX_SLICES-1:0] exists;
   logic [MAX_SLICES-1:0] free_vec;
   logic [MAX_SLICES-1:0] elig_vec;
   logic [IDX_W-1:0]      tgt;
   logic [IDX_W-1:0]      pick_idx;
   logic [GRP_W-1:0]      pick_grp;
   logic                  pick_any;

   // slice count, saturated
   always_comb begin
      raw_count = (CNT_W+1)'(piece_length_ff[PLEN_W-1:SLICE_SHIFT])
                + (CNT_W+1)'(piece_length_ff[SLICE_SHIFT-1:0] != '0);
      if (raw_count > (CNT_W+1)'(MAX_SLICES))
         slice_count = CNT_W'(MAX_SLICES);
      else
         slice_count = raw_count[CNT_W-1:0];
      for (int i = 0; i < MAX_SLICES; i++) begin
         exists[i] = CNT_W'(i) < slice_count;
      end
   end

   assign free_vec = ~req_vec_ff & ~done_vec_ff;
   assign elig_vec = exists & (free_vec | ({MAX_SLICES{endgame_ff}} & req_vec_ff));
   assign tgt      = off_ff[SLICE_SHIFT +: IDX_W];

   // find: per-group first eligible slice, and direct target match
   always_comb begin
      for (int g = 0; g < GRP_CNT; g++) begin
         grp_any_in[g]   = |elig_vec[g*GRP_SIZE +: GRP_SIZE];
         grp_first_in[g] = '0;
         for (int s = GRP_SIZE - 1; s >= 0; s--) begin
            if (elig_vec[g*GRP_SIZE + s]) grp_first_in[g] = SUB_W'(s);
         end
      end
      match_in = (off_ff[SLICE_SHIFT-1:0] == '0) && exists[tgt]
              && (slice_size(tgt, piece_length_ff) == len_ff) && !done_vec_ff[tgt]
              && (req_vec_ff[tgt] || (kind_ff == KIND_COMPLETE));
   end

   // update
   always_comb begin
      pick_any = |grp_any_ff;
      pick_grp = '0;
      for (int g = GRP_CNT - 1; g >= 0; g--) begin
         if (grp_any_ff[g]) pick_grp = GRP_W'(g);
      end
      pick_idx = {pick_grp, grp_first_ff[pick_grp]};

      req_vec_in  = req_vec_ff;
      done_vec_in = done_vec_ff;
      ok_in       = ok_ff;
      gp_in       = gp_ff;
      go_in       = go_ff;
      gl_in       = gl_ff;
      if (csr_write && csr_index == CSR_PIECE_LENGTH) begin
         req_vec_in  = '0;
         done_vec_in = '0;
      end else if (cmd.update) begin
         ok_in = 1'b0;
         gp_in = '0;
         go_in = '0;
         gl_in = '0;
         case (kind_ff)
            KIND_RESTART: begin
               req_vec_in  = '0;
               done_vec_in = '0;
               ok_in       = 1'b1;
            end
            KIND_REQUEST: begin
               if (pick_any) begin
                  req_vec_in[pick_idx] = 1'b1;
                  ok_in = 1'b1;
                  gp_in = piece_number_ff;
                  go_in = OFF_W'({pick_idx, {SLICE_SHIFT{1'b0}}});
                  gl_in = slice_size(pick_idx, piece_length_ff);
               end
            end
            KIND_ABORT: begin
               ok_in = match_ff;
               if (match_ff) req_vec_in[tgt] = 1'b0;
            end
            default: begin
               ok_in = match_ff;
               if (match_ff) begin
                  req_vec_in[tgt]  = 1'b0;
                  done_vec_in[tgt] = 1'b1;
               end
            end
         endcase
      end
   end

   // sum: per-group status over the updated vectors
   always_comb begin
      for (int g = 0; g < GRP_CNT; g++) begin
         grp_done_in[g] = &(done_vec_ff[g*GRP_SIZE +: GRP_SIZE]
                            | ~exists[g*GRP_SIZE +: GRP_SIZE]);
         grp_none_in[g] = &(free_vec[g*GRP_SIZE +: GRP_SIZE]
                            | ~exists[g*GRP_SIZE +: GRP_SIZE]);
         grp_free_in[g] = |elig_vec[g*GRP_SIZE +: GRP_SIZE];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         piece_length_ff <= PLEN_RESET;
         piece_number_ff <= '0;
         req_vec_ff      <= '0;
         done_vec_ff     <= '0;
      end else begin
         if (csr_write && csr_index == CSR_PIECE_LENGTH)
            piece_length_ff <= csr_wdata[PLEN_W-1:0];
         if (csr_write && csr_index == CSR_PIECE_NUMBER)
            piece_number_ff <= csr_wdata[PNUM_W-1:0];
         req_vec_ff  <= req_vec_in;
         done_vec_ff <= done_vec_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff    <= kind_type'(req_kind);
         off_ff     <= req_start_offset;
         len_ff     <= req_length_given;
         endgame_ff <= req_endgame;
      end
      if (cmd.find) begin
         grp_any_ff   <= grp_any_in;
         grp_first_ff <= grp_first_in;
         match_ff     <= match_in;
      end
      ok_ff <= ok_in;
      gp_ff <= gp_in;
      go_ff <= go_in;
      gl_ff <= gl_in;
      if (cmd.sum) begin
         grp_done_ff <= grp_done_in;
         grp_none_ff <= grp_none_in;
         grp_free_ff <= grp_free_in;
      end
   end

   assign rsp_ok             = ok_ff;
   assign rsp_granted_piece  = gp_ff;
   assign rsp_granted_offset = go_ff;
   assign rsp_granted_length = gl_ff;
   assign rsp_all_completed  = &grp_done_ff;
   assign rsp_none_requested = &grp_none_ff;
   assign rsp_has_free_slice = |grp_free_ff;

endmodule

@@ src/slice_request_tracker_unit.sv @@
// ----------------------------------------------------------------------------
// slice_request_tracker_unit: slice request tracker top level
// One item is taken at a time. Its result appears on the rsp_ ports for one
// cycle with rsp_strobe, in the controller's response step, which follows its
// find, update and sum steps; busy stays high until that cycle ends, so a new
// item cannot be started before then. The first-free search and the status
// flags run as two-level trees over eight groups of eight slices. The result
// must be taken when strobed. busy is also held high during reset. Register
// writes are taken (csr_ready high) only while busy and start are both low; a
// piece length write frees every slice.
// No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module slice_request_tracker_unit
   import srt_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [1:0]        req_kind,
   input  logic [OFF_W-1:0]  req_start_offset,
   input  logic [LEN_W-1:0]  req_length_given,
   input  logic              req_endgame,
   output logic              rsp_strobe,
   output logic              rsp_ok,
   output logic [PNUM_W-1:0] rsp_granted_piece,
   output logic [OFF_W-1:0]  rsp_granted_offset,
   output logic [LEN_W-1:0]  rsp_granted_length,
   output logic              rsp_all_completed,
   output logic              rsp_none_requested,
   output logic              rsp_has_free_slice,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_index,
   input  logic [CSR_W-1:0]  csr_wdata
);

   cmd_type cmd;
   logic    csr_write;

   assign csr_ready  = ~busy & ~start;
   assign csr_write  = csr_valid & csr_ready;
   assign rsp_strobe = cmd.respond;

   srt_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd)
   );

   srt_dpath u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .csr_write          (csr_write),
      .csr_index          (csr_index_type'(csr_index)),
      .csr_wdata          (csr_wdata),
      .req_kind           (req_kind),
      .req_start_offset   (req_start_offset),
      .req_length_given   (req_length_given),
      .req_endgame        (req_endgame),
      .rsp_ok             (rsp_ok),
      .rsp_granted_piece  (rsp_granted_piece),
      .rsp_granted_offset (rsp_granted_offset),
      .rsp_granted_length (rsp_granted_length),
      .rsp_all_completed  (rsp_all_completed),
      .rsp_none_requested (rsp_none_requested),
      .rsp_has_free_slice (rsp_has_free_slice)
   );

`ifndef SYNTHESIS
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("result strobe outside busy window");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##4 rsp_strobe)
      else $error("result not returned four cycles after start");

   a_grant_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_granted_length != '0) |-> rsp_ok)
      else $error("grant length without ok");
`endif

endmodule
